[rtl/lfu_pkg.sv]
package lfu_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int USED_W  = $clog2(ENTRIES + 1);
  localparam int RANK_W  = IDX_W;
  localparam int CAP_W   = 5;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  data;
    logic [CNT_W-1:0]  count;
    logic [RANK_W-1:0] rank;
  } entry_t;

endpackage

[rtl/lfu_req_if.sv]
interface lfu_req_if;
  import lfu_pkg::*;

  logic                    valid;
  logic                    ready;
  op_t                     operation;
  logic signed [KEY_W-1:0] lookup_key;
  logic signed [VAL_W-1:0] write_value;

  modport source (output valid, output operation, output lookup_key, output write_value,
                  input ready);
  modport sink (input valid, input operation, input lookup_key, input write_value,
                output ready);
endinterface

[rtl/lfu_rsp_if.sv]
interface lfu_rsp_if;
  import lfu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [VAL_W-1:0] read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink (input valid, input hit, input read_value, output ready);
endinterface

[rtl/lfu_cfg_if.sv]
interface lfu_cfg_if;
  import lfu_pkg::*;

  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/lfu_cache_table.sv]
// Key/value cache with least-frequently-used replacement and least-recently-used
// tie-break. One request transaction gives exactly one response transaction. Entries
// live in a single-port-read, single-port-write memory; every request makes one pass
// over the memory that finds the key, the victim and the first free slot, and a second
// read-modify-write pass then updates use counts and recency ranks. A get miss, or a
// put while the capacity is zero, skips the second pass. The capacity register is
// always ready.
module lfu_cache_table (
  input  logic       clk,
  input  logic       rst,
  lfu_req_if.sink    req,
  lfu_rsp_if.source  rsp,
  lfu_cfg_if.sink    cfg
);
  import lfu_pkg::*;

  localparam int CMP_W = (USED_W > CAP_W) ? USED_W : CAP_W;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_DRAIN  = 6'b000100,
    ST_REPLY  = 6'b001000,
    ST_SWEEP  = 6'b010000,
    ST_SDRAIN = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    MODE_TOUCH = 3'b001,
    MODE_EVICT = 3'b010,
    MODE_FILL  = 3'b100
  } mode_t;

  state_t state;
  mode_t  mode;

  entry_t mem [ENTRIES];
  entry_t rd_data;
  entry_t wdata;
  logic   mem_we;

  logic [ENTRIES-1:0] slot_valid;
  logic [CAP_W-1:0]   capacity;

  logic [IDX_W-1:0] cnt;
  logic             cnt_last;
  logic             ev_valid;
  logic [IDX_W-1:0] ev_idx;
  logic             ev_slot_valid;
  logic             ev_is_tgt;

  op_t              op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;

  logic              found_ok;
  logic [IDX_W-1:0]  found_idx;
  logic [VAL_W-1:0]  found_data;
  logic [RANK_W-1:0] found_rank;
  logic              vic_ok;
  logic [IDX_W-1:0]  vic_idx;
  logic [CNT_W-1:0]  vic_cnt;
  logic [RANK_W-1:0] vic_rank;
  logic              free_ok;
  logic [IDX_W-1:0]  free_idx;
  logic [USED_W-1:0] used;

  logic [IDX_W-1:0]  tgt_idx;
  logic [RANK_W-1:0] tgt_rank;

  logic             rsp_valid;
  logic             rsp_hit;
  logic [VAL_W-1:0] rsp_value;

  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] eff_cap;
  logic             cap_zero;
  logic             full;
  logic             do_touch;
  logic             do_insert;
  logic             evicting;
  logic             act;
  logic             out_free;
  logic             accept;

  assign req.ready      = (state == ST_IDLE);
  assign cfg.ready      = 1'b1;
  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_hit;
  assign rsp.read_value = rsp_value;

  assign accept   = req.valid && (state == ST_IDLE);
  assign cnt_last = (cnt == IDX_W'(ENTRIES - 1));
  assign out_free = !rsp_valid || rsp.ready;

  assign cap_ext   = CMP_W'(capacity);
  assign eff_cap   = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
  assign cap_zero  = (eff_cap == '0);
  assign full      = (CMP_W'(used) >= eff_cap) || !free_ok;
  assign do_touch  = found_ok && ((op_r == OP_GET) || !cap_zero);
  assign evicting  = full;
  assign do_insert = (op_r == OP_PUT) && !cap_zero && !found_ok && (!evicting || vic_ok);
  assign act       = do_touch || do_insert;

  assign ev_slot_valid = slot_valid[ev_idx];
  assign ev_is_tgt     = (ev_idx == tgt_idx);

  always_ff @(posedge clk) begin
    if ((state == ST_SCAN) || (state == ST_SWEEP)) begin
      rd_data <= mem[cnt];
    end
    if (mem_we) begin
      mem[ev_idx] <= wdata;
    end
  end

  always_comb begin
    wdata  = rd_data;
    mem_we = 1'b0;
    if (ev_valid && ((state == ST_SWEEP) || (state == ST_SDRAIN))) begin
      if (ev_is_tgt) begin
        mem_we     = 1'b1;
        wdata.rank = '0;
        unique case (mode)
          MODE_TOUCH: begin
            if (rd_data.count != COUNT_MAX) begin
              wdata.count = rd_data.count + CNT_W'(1);
            end
            if (op_r == OP_PUT) begin
              wdata.data = val_r;
            end
          end
          MODE_EVICT, MODE_FILL: begin
            wdata.key   = key_r;
            wdata.data  = val_r;
            wdata.count = CNT_W'(1);
          end
          default: begin
            mem_we = 1'b0;
          end
        endcase
      end else if (ev_slot_valid) begin
        mem_we = 1'b1;
        unique case (mode)
          MODE_TOUCH: begin
            if (rd_data.rank < tgt_rank) begin
              wdata.rank = rd_data.rank + RANK_W'(1);
            end
          end
          MODE_EVICT: begin
            if (rd_data.rank <= tgt_rank) begin
              wdata.rank = rd_data.rank + RANK_W'(1);
            end
          end
          MODE_FILL: begin
            wdata.rank = rd_data.rank + RANK_W'(1);
          end
          default: begin
            mem_we = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg.valid) begin
      capacity <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ev_valid   <= 1'b0;
      slot_valid <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      ev_valid <= (state == ST_SCAN) || (state == ST_SWEEP);
      if (mem_we && ev_is_tgt) begin
        slot_valid[ev_idx] <= 1'b1;
      end
      if ((state == ST_REPLY) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_REPLY;
        end
        ST_REPLY: begin
          if (out_free) begin
            state <= act ? ST_SWEEP : ST_IDLE;
          end
        end
        ST_SWEEP: begin
          if (cnt_last) begin
            state <= ST_SDRAIN;
          end
        end
        ST_SDRAIN: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ev_idx <= cnt;
    if ((state == ST_SCAN) || (state == ST_SWEEP)) begin
      cnt <= cnt + IDX_W'(1);
    end else begin
      cnt <= '0;
    end

    if (accept) begin
      op_r     <= req.operation;
      key_r    <= req.lookup_key;
      val_r    <= req.write_value;
      found_ok <= 1'b0;
      vic_ok   <= 1'b0;
      free_ok  <= 1'b0;
      used     <= '0;
    end else if (ev_valid && ((state == ST_SCAN) || (state == ST_DRAIN))) begin
      if (ev_slot_valid) begin
        used <= used + USED_W'(1);
        if (!found_ok && (rd_data.key == key_r)) begin
          found_ok   <= 1'b1;
          found_idx  <= ev_idx;
          found_data <= rd_data.data;
          found_rank <= rd_data.rank;
        end
        if (!vic_ok || (rd_data.count < vic_cnt) ||
            ((rd_data.count == vic_cnt) && (rd_data.rank > vic_rank))) begin
          vic_ok   <= 1'b1;
          vic_idx  <= ev_idx;
          vic_cnt  <= rd_data.count;
          vic_rank <= rd_data.rank;
        end
      end else if (!free_ok) begin
        free_ok  <= 1'b1;
        free_idx <= ev_idx;
      end
    end

    if ((state == ST_REPLY) && out_free) begin
      rsp_hit   <= found_ok;
      rsp_value <= ((op_r == OP_GET) && found_ok) ? found_data : '0;
      if (do_touch) begin
        mode     <= MODE_TOUCH;
        tgt_idx  <= found_idx;
        tgt_rank <= found_rank;
      end else if (evicting) begin
        mode     <= MODE_EVICT;
        tgt_idx  <= vic_idx;
        tgt_rank <= vic_rank;
      end else begin
        mode     <= MODE_FILL;
        tgt_idx  <= free_idx;
        tgt_rank <= '0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_write_in_sweep: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == ST_SWEEP) || (state == ST_SDRAIN)))
    else $error("memory written outside the update pass");

  a_rsp_from_reply: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_REPLY))
    else $error("response raised outside the reply state");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN) && (cnt == '0))
    else $error("accepted transaction did not start a scan");

  a_one_insert: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($countones(slot_valid) <= $past($countones(slot_valid)) + 1))
    else $error("more than one slot became valid at once");

  a_reply_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPLY) && !act && out_free |=> (state == ST_IDLE))
    else $error("request without update did not return to idle");
`endif

endmodule

[test/lfu_cache_table_checker.sv]
`timescale 1ns / 1ps

module lfu_cache_table_checker
  import lfu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  lfu_req_if          req,
  lfu_rsp_if          rsp,
  lfu_cfg_if          cfg,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned responses,
  output int unsigned hits
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value;
  } reply_t;

  logic             live  [ENTRIES];
  logic [KEY_W-1:0] tag   [ENTRIES];
  logic [VAL_W-1:0] held  [ENTRIES];
  logic [CNT_W-1:0] uses  [ENTRIES];
  int unsigned      age   [ENTRIES];
  logic [CAP_W-1:0] capacity;
  reply_t           replies_due [$];

  function automatic void promote(int s);
    for (int i = 0; i < ENTRIES; i++) begin
      if (live[i] && i != s && age[i] < age[s]) age[i]++;
    end
    age[s] = 0;
  endfunction

  function automatic void bump_uses(int s);
    if (uses[s] != COUNT_MAX) uses[s]++;
  endfunction

  function automatic void drop(int s);
    live[s] = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (live[i] && age[i] > age[s]) age[i]--;
    end
  endfunction

  // Looks up the key, applies the get or put to the cache image and returns the reply.
  function automatic reply_t serve_request(op_t op, logic [KEY_W-1:0] key,
                                           logic [VAL_W-1:0] data);
    reply_t      reply;
    int          found, free_idx, victim, target;
    int unsigned used, limit;
    found = -1;
    free_idx = -1;
    victim = -1;
    used = 0;
    limit = (capacity > ENTRIES) ? ENTRIES : capacity;
    for (int i = 0; i < ENTRIES; i++) begin
      if (live[i]) begin
        used++;
        if (found < 0 && tag[i] == key) found = i;
        if (victim < 0 || uses[i] < uses[victim] ||
            (uses[i] == uses[victim] && age[i] > age[victim])) victim = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    reply.hit = (found >= 0);
    reply.value = '0;
    if (op == OP_GET) begin
      if (found >= 0) begin
        reply.value = held[found];
        bump_uses(found);
        promote(found);
      end
    end else if (limit != 0) begin
      if (found >= 0) begin
        held[found] = data;
        bump_uses(found);
        promote(found);
      end else begin
        if (used >= limit || free_idx < 0) begin
          drop(victim);
          target = victim;
        end else begin
          target = free_idx;
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (live[i]) age[i]++;
        end
        live[target] = 1'b1;
        tag[target] = key;
        held[target] = data;
        uses[target] = 1;
        age[target] = 0;
      end
    end
    return reply;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) live[i] = 1'b0;
      capacity = CAP_RESET;
      replies_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) capacity = cfg.data;
      if (req.valid && req.ready) begin
        replies_due.push_back(serve_request(req.operation, req.lookup_key, req.write_value));
      end
      if (rsp.valid && rsp.ready) begin
        responses++;
        if (rsp.hit) hits++;
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: response transaction with nothing outstanding: hit=%0b value=%h",
                     $realtime, rsp.hit, rsp.read_value);
          end
        end else begin
          want = replies_due.pop_front();
          if (rsp.hit !== want.hit || rsp.read_value !== want.value) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: response %0d expected hit=%0b value=%h, got hit=%0b value=%h",
                       $realtime, responses, want.hit, want.value, rsp.hit, rsp.read_value);
            end
          end
        end
      end
    end
    pending = replies_due.size();
  end

endmodule

[test/tb_lfu_cache_table.sv]
`timescale 1ns / 1ps

module tb_lfu_cache_table;
  import lfu_pkg::*;

  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 113;
  localparam int POOL_SIZE     = 24;
  localparam int SETTLE_CYCLES = 2 * ENTRIES + 8;
  localparam logic [CAP_W-1:0] PHASE_CAPS [PHASES] = '{16, 1, 31, 0, 5, 17, 3, 16, 8, 12};

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  int unsigned      sender_idle_pct = 0;
  int unsigned      receiver_stall_pct = 0;
  int unsigned      sent = 0;
  int unsigned      puts_sent = 0;
  int unsigned      mismatches, pending, responses, hits;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  lfu_req_if req ();
  lfu_rsp_if rsp ();
  lfu_cfg_if cfg ();

  lfu_cache_table dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  lfu_cache_table_checker reply_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .cfg        (cfg),
    .mismatches (mismatches),
    .pending    (pending),
    .responses  (responses),
    .hits       (hits)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    rsp.ready <= !rst && ($urandom_range(99) >= receiver_stall_pct);
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_request(input op_t op, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] data);
    while ($urandom_range(99) < sender_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.lookup_key <= key;
    req.write_value <= data;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent++;
    if (op == OP_PUT) puts_sent++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Mostly reuses a small key set so that hits, updates and evictions are frequent.
  function automatic logic [KEY_W-1:0] pick_key(int span);
    if ($urandom_range(99) < 6) return $urandom;
    return key_pool[$urandom_range(span - 1)];
  endfunction

  initial begin
    int  span;
    op_t op;
    req.valid = 1'b0;
    req.operation = OP_GET;
    req.lookup_key = '0;
    req.write_value = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    rsp.ready = 1'b0;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_request(OP_GET, 32'h0000_0000, 32'h1234_5678);
    send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_PUT, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    drain();

    // Capacity below the current occupancy: each insert replaces one victim.
    set_capacity(2);
    send_request(OP_PUT, 32'h0000_0011, 32'h0000_0001);
    send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(OP_PUT, 32'h0000_0022, 32'h0000_0002);
    send_request(OP_GET, 32'h0000_0011, 32'h0000_0000);
    drain();

    set_capacity(0);
    send_request(OP_PUT, 32'h0000_0033, 32'h0000_0003);
    send_request(OP_PUT, 32'h7FFF_FFFF, 32'h0000_0001);
    send_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(OP_GET, 32'h0000_0033, 32'h0000_0000);
    drain();

    set_capacity(31);
    send_request(OP_PUT, 32'h0000_0044, 32'hA5A5_A5A5);
    send_request(OP_GET, 32'h0000_0044, 32'h0000_0000);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_capacity(PHASE_CAPS[p]);
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 74;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 74;
        end
        default: begin
          sender_idle_pct = 23;
          receiver_stall_pct = 23;
        end
      endcase
      span = (PHASE_CAPS[p] >= 20) ? POOL_SIZE : int'(PHASE_CAPS[p]) + 4;
      repeat (PHASE_ITEMS) begin
        op = ($urandom_range(99) < 45) ? OP_PUT : OP_GET;
        send_request(op, pick_key(span), $urandom);
      end
    end
    drain();

    $display("Checked %0d responses (%0d hits) for %0d requests, %0d of them puts.",
             responses, hits, sent, puts_sent);
    $display("Capacities from 0 to 31 were used, with sender gaps and receiver stalls.");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/lfu_pkg.sv
rtl/lfu_req_if.sv
rtl/lfu_rsp_if.sv
rtl/lfu_cfg_if.sv
rtl/lfu_cache_table.sv
test/lfu_cache_table_checker.sv
test/tb_lfu_cache_table.sv
